// File: src/cnms_pkg.sv
// ----------------------------------------------------------------------------
// cnms_pkg: shared types and constants for the cron next-match search
// Configuration layout, controller commands, calendar helper functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cnms_pkg;

    localparam int unsigned SEARCH_DAYS_DEF = 1461;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 60;

    localparam int unsigned MIN_LAST   = 59;
    localparam int unsigned HOUR_LAST  = 23;
    localparam int unsigned MON_LAST   = 12;
    localparam int unsigned MON_MARCH  = 3;
    localparam int unsigned WDAY_LAST  = 6;
    localparam int unsigned WEEK_DAYS  = 7;

    localparam int unsigned CENTURY      = 100;
    localparam int unsigned QUAD_CENTURY = 400;
    localparam int unsigned YEAR_SHIFT   = 400;
    localparam int unsigned YS_DIV4      = YEAR_SHIFT / 4;
    localparam int unsigned YS_DIV100    = YEAR_SHIFT / 100;
    localparam int unsigned YS_DIV400    = YEAR_SHIFT / 400;

    // x / 25 = (x * DIV25_MUL) >> DIV25_SHIFT, exact for x < 4096
    localparam int unsigned DIV25_MUL   = 5243;
    localparam int unsigned DIV25_SHIFT = 17;
    // x / 7 = (x * DIV7_MUL) >> DIV7_SHIFT, exact for x < 32768
    localparam int unsigned DIV7_MUL    = 37450;
    localparam int unsigned DIV7_SHIFT  = 18;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MINUTE    = 3'd0,
        REG_HOUR      = 3'd1,
        REG_DAY       = 3'd2,
        REG_MONTH     = 3'd3,
        REG_WEEKDAY   = 3'd4,
        REG_DAY_WILD  = 3'd5,
        REG_WDAY_WILD = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [59:0] minute_mask;
        logic [23:0] hour_mask;
        logic [31:0] day_mask;
        logic [12:0] month_mask;
        logic [6:0]  weekday_mask;
        logic        day_wild;
        logic        wday_wild;
    } t_cfg;

    localparam logic [59:0] MINUTE_MASK_RST  = 60'hFFF_FFFF_FFFF_FFFF;
    localparam logic [23:0] HOUR_MASK_RST    = 24'hFF_FFFF;
    localparam logic [31:0] DAY_MASK_RST     = 32'hFFFF_FFFE;
    localparam logic [12:0] MONTH_MASK_RST   = 13'h1FFE;
    localparam logic [6:0]  WEEKDAY_MASK_RST = 7'h7F;

    typedef enum logic [3:0] {
        CMD_IDLE,
        CMD_LOAD,
        CMD_QUOT,
        CMD_REM,
        CMD_CLAMP,
        CMD_WSUM,
        CMD_WDIV,
        CMD_WREM,
        CMD_ADV_MIN,
        CMD_STEP
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_QUOT,
        ST_REM,
        ST_CLAMP,
        ST_WSUM,
        ST_WDIV,
        ST_WREM,
        ST_ADV_MIN,
        ST_SEARCH
    } t_state;

    typedef struct packed {
        logic hit;
        logic miss;
    } t_status;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd2: begin
                len = leap ? 5'd29 : 5'd28;
            end
            4'd4, 4'd6, 4'd9, 4'd11: begin
                len = 5'd30;
            end
            default: begin
                len = 5'd31;
            end
        endcase
        return len;
    endfunction

    // weekday offset of the first of each month, March-based year
    function automatic logic [2:0] month_offset(input logic [3:0] m);
        logic [2:0] t;
        case (m)
            4'd1:    t = 3'd0;
            4'd2:    t = 3'd3;
            4'd3:    t = 3'd2;
            4'd4:    t = 3'd5;
            4'd5:    t = 3'd0;
            4'd6:    t = 3'd3;
            4'd7:    t = 3'd5;
            4'd8:    t = 3'd1;
            4'd9:    t = 3'd4;
            4'd10:   t = 3'd6;
            4'd11:   t = 3'd2;
            4'd12:   t = 3'd4;
            default: t = 3'd0;
        endcase
        return t;
    endfunction

    // v < 42
    function automatic logic [2:0] mod7_small(input logic [5:0] v);
        logic [5:0] r;
        r = v;
        for (int k = 0; k < 5; k++) begin
            if (r >= 6'(WEEK_DAYS)) begin
                r = r - 6'(WEEK_DAYS);
            end
        end
        return r[2:0];
    endfunction

endpackage

// File: src/cron_next_match_search.sv
// ----------------------------------------------------------------------------
// cron_next_match_search: next minute matching a cron schedule
// Given a start time, finds the first later minute allowed by the schedule
// masks, searching the Gregorian calendar up to SEARCH_DAYS days ahead.
//
// Usage:
//   Command channel: an item is taken on a rising edge with start high and
//   busy low. busy stays high until the search ends. The result is shown
//   for exactly one cycle with o_result_valid; the receiver cannot stall,
//   so it must capture the result in that cycle.
//   Config channel: i_cfg_valid / o_cfg_ready (always ready), register
//   index i_cfg_index, data i_cfg_data. Write only while busy is low.
//   Search: setup (clamp, year residues, start weekday), then one
//   candidate tried per cycle until a match or a miss. A candidate
//   is a skipped month, a skipped day, a skipped hour or a skipped minute.
//   One item at a time: a new item is taken the cycle the strobe shows.
//   Reset: synchronous, active low; returns to idle and restores the
//   schedule to every minute allowed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cron_next_match_search
    import cnms_pkg::*;
#(
    parameter int unsigned SEARCH_DAYS = SEARCH_DAYS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [13:0]           i_start_year,
    input  logic [3:0]            i_start_month,
    input  logic [4:0]            i_start_day,
    input  logic [4:0]            i_start_hour,
    input  logic [5:0]            i_start_minute,
    output logic                  o_result_valid,
    output logic                  o_found,
    output logic [13:0]           o_next_year,
    output logic [3:0]            o_next_month,
    output logic [4:0]            o_next_day,
    output logic [4:0]            o_next_hour,
    output logic [5:0]            o_next_minute,
    output logic [2:0]            o_next_weekday,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    cfg;
    t_cmd    cmd;
    t_status status;

    cnms_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    cnms_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_busy   (busy),
        .o_cmd    (cmd),
        .o_done   (o_result_valid)
    );

    cnms_dpath #(
        .SEARCH_DAYS (SEARCH_DAYS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_cmd          (cmd),
        .i_cfg          (cfg),
        .i_start_year   (i_start_year),
        .i_start_month  (i_start_month),
        .i_start_day    (i_start_day),
        .i_start_hour   (i_start_hour),
        .i_start_minute (i_start_minute),
        .o_status       (status),
        .o_found        (o_found),
        .o_next_year    (o_next_year),
        .o_next_month   (o_next_month),
        .o_next_day     (o_next_day),
        .o_next_hour    (o_next_hour),
        .o_next_minute  (o_next_minute),
        .o_next_weekday (o_next_weekday)
    );

endmodule

// File: src/cnms_cfg.sv
// ----------------------------------------------------------------------------
// cnms_cfg: schedule register bank
// Holds the cron masks and wild flags, written through the config channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cnms_cfg
    import cnms_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.minute_mask  <= MINUTE_MASK_RST;
            r_cfg.hour_mask    <= HOUR_MASK_RST;
            r_cfg.day_mask     <= DAY_MASK_RST;
            r_cfg.month_mask   <= MONTH_MASK_RST;
            r_cfg.weekday_mask <= WEEKDAY_MASK_RST;
            r_cfg.day_wild     <= 1'b1;
            r_cfg.wday_wild    <= 1'b1;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_MINUTE:    r_cfg.minute_mask  <= i_cfg_data[59:0];
                REG_HOUR:      r_cfg.hour_mask    <= i_cfg_data[23:0];
                REG_DAY:       r_cfg.day_mask     <= i_cfg_data[31:0];
                REG_MONTH:     r_cfg.month_mask   <= i_cfg_data[12:0];
                REG_WEEKDAY:   r_cfg.weekday_mask <= i_cfg_data[6:0];
                REG_DAY_WILD:  r_cfg.day_wild     <= i_cfg_data[0];
                REG_WDAY_WILD: r_cfg.wday_wild    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

endmodule

// File: src/cnms_ctrl.sv
// ----------------------------------------------------------------------------
// cnms_ctrl: search sequencer
// Steps the datapath through setup, then one candidate per cycle to the end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cnms_ctrl
    import cnms_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    output logic    o_busy,
    output t_cmd    o_cmd,
    output logic    o_done
);

    t_state r_state;
    t_state n_state;
    logic   r_done;
    logic   n_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        o_cmd   = CMD_IDLE;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd   = CMD_LOAD;
                    n_state = ST_QUOT;
                end
            end
            ST_QUOT: begin
                o_cmd   = CMD_QUOT;
                n_state = ST_REM;
            end
            ST_REM: begin
                o_cmd   = CMD_REM;
                n_state = ST_CLAMP;
            end
            ST_CLAMP: begin
                o_cmd   = CMD_CLAMP;
                n_state = ST_WSUM;
            end
            ST_WSUM: begin
                o_cmd   = CMD_WSUM;
                n_state = ST_WDIV;
            end
            ST_WDIV: begin
                o_cmd   = CMD_WDIV;
                n_state = ST_WREM;
            end
            ST_WREM: begin
                o_cmd   = CMD_WREM;
                n_state = ST_ADV_MIN;
            end
            ST_ADV_MIN: begin
                o_cmd   = CMD_ADV_MIN;
                n_state = ST_SEARCH;
            end
            ST_SEARCH: begin
                o_cmd = CMD_STEP;
                if (i_status.hit || i_status.miss) begin
                    n_state = ST_IDLE;
                    n_done  = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_done = r_done;

endmodule

// File: src/cnms_dpath.sv
// ----------------------------------------------------------------------------
// cnms_dpath: calendar walk datapath
// Start-date setup (clamp, year residues, weekday) and the per-cycle
// candidate step over month, day, hour and minute.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cnms_dpath
    import cnms_pkg::*;
#(
    parameter int unsigned SEARCH_DAYS = SEARCH_DAYS_DEF
) (
    input  logic        i_clk,
    input  t_cmd        i_cmd,
    input  t_cfg        i_cfg,
    input  logic [13:0] i_start_year,
    input  logic [3:0]  i_start_month,
    input  logic [4:0]  i_start_day,
    input  logic [4:0]  i_start_hour,
    input  logic [5:0]  i_start_minute,
    output t_status     o_status,
    output logic        o_found,
    output logic [13:0] o_next_year,
    output logic [3:0]  o_next_month,
    output logic [4:0]  o_next_day,
    output logic [4:0]  o_next_hour,
    output logic [5:0]  o_next_minute,
    output logic [2:0]  o_next_weekday
);

    localparam int unsigned CNT_W = $clog2(SEARCH_DAYS + 32);

    logic [14:0]      r_year,  n_year;
    logic [3:0]       r_month, n_month;
    logic [4:0]       r_day,   n_day;
    logic [4:0]       r_hour,  n_hour;
    logic [5:0]       r_min,   n_min;
    logic [2:0]       r_wday,  n_wday;
    logic [1:0]       r_ym4,   n_ym4;
    logic [6:0]       r_ym100, n_ym100;
    logic [8:0]       r_ym400, n_ym400;
    logic [7:0]       r_q100,  n_q100;
    logic [5:0]       r_q400,  n_q400;
    logic [15:0]      r_wsum,  n_wsum;
    logic [11:0]      r_wq,    n_wq;
    logic [CNT_W-1:0] r_cnt,   n_cnt;

    logic        r_found, n_found;
    logic [13:0] r_ny,    n_ny;
    logic [3:0]  r_nm,    n_nm;
    logic [4:0]  r_nd,    n_nd;
    logic [4:0]  r_nh,    n_nh;
    logic [5:0]  r_nmin,  n_nmin;
    logic [2:0]  r_nwd,   n_nwd;

    logic        leap;
    logic [4:0]  mlen;

    logic [14:0] nm_year;
    logic [3:0]  nm_month;
    logic [1:0]  nm_ym4;
    logic [6:0]  nm_ym100;
    logic [8:0]  nm_ym400;
    logic [5:0]  nm_delta;
    logic [2:0]  nm_wday;

    logic [4:0]  nd_day;
    logic [2:0]  nd_wday;
    logic        nd_wrap;

    logic [5:0]  am_min;
    logic [4:0]  am_hour;
    logic        am_roll;

    logic        month_ok, dom_ok, dow_ok, day_ok, hour_ok, min_ok, miss;
    logic        go_day, go_month;

    logic [25:0] prod100, prod400;
    logic [31:0] prod7;
    logic        early;
    logic [15:0] ya, fa4, fa100, fa400;

    assign leap = ((r_ym4 == 2'd0) && (r_ym100 != 7'd0)) || (r_ym400 == 9'd0);
    assign mlen = month_len(r_month, leap);

    // first of the following month
    always_comb begin
        if (r_month == 4'(MON_LAST)) begin
            nm_month = 4'd1;
            nm_year  = r_year + 15'd1;
            nm_ym4   = r_ym4 + 2'd1;
            nm_ym100 = (r_ym100 == 7'(CENTURY - 1)) ? 7'd0 : r_ym100 + 7'd1;
            nm_ym400 = (r_ym400 == 9'(QUAD_CENTURY - 1)) ? 9'd0 : r_ym400 + 9'd1;
        end else begin
            nm_month = r_month + 4'd1;
            nm_year  = r_year;
            nm_ym4   = r_ym4;
            nm_ym100 = r_ym100;
            nm_ym400 = r_ym400;
        end
    end

    assign nm_delta = 6'(mlen) - 6'(r_day) + 6'd1;
    assign nm_wday  = mod7_small(6'(r_wday) + nm_delta);

    assign nd_wrap = (r_day == mlen);
    assign nd_day  = r_day + 5'd1;
    assign nd_wday = (r_wday == 3'(WDAY_LAST)) ? 3'd0 : r_wday + 3'd1;

    always_comb begin
        am_roll = 1'b0;
        am_hour = r_hour;
        am_min  = r_min + 6'd1;
        if (r_min == 6'(MIN_LAST)) begin
            am_min = 6'd0;
            if (r_hour == 5'(HOUR_LAST)) begin
                am_hour = 5'd0;
                am_roll = 1'b1;
            end else begin
                am_hour = r_hour + 5'd1;
            end
        end
    end

    assign month_ok = i_cfg.month_mask[r_month];
    assign dom_ok   = i_cfg.day_mask[r_day];
    assign dow_ok   = i_cfg.weekday_mask[r_wday];
    assign day_ok   = (i_cfg.day_wild || i_cfg.wday_wild) ? (dom_ok && dow_ok)
                                                          : (dom_ok || dow_ok);
    assign hour_ok  = i_cfg.hour_mask[r_hour];
    assign min_ok   = i_cfg.minute_mask[r_min];
    assign miss     = (r_cnt > CNT_W'(SEARCH_DAYS));

    assign o_status.miss = miss;
    assign o_status.hit  = !miss && month_ok && day_ok && hour_ok && min_ok;

    // weekday of the start date, year taken March-based and shifted one era
    assign prod100 = 26'(r_year[13:2]) * 26'(DIV25_MUL);
    assign prod400 = 26'(r_year[13:4]) * 26'(DIV25_MUL);
    assign early   = (r_month < 4'(MON_MARCH));
    assign ya      = 16'(r_year) + 16'(YEAR_SHIFT) - 16'(early);
    assign fa4     = 16'(r_year[14:2]) + 16'(YS_DIV4) - 16'(early && (r_ym4 == 2'd0));
    assign fa100   = 16'(r_q100) + 16'(YS_DIV100) - 16'(early && (r_ym100 == 7'd0));
    assign fa400   = 16'(r_q400) + 16'(YS_DIV400) - 16'(early && (r_ym400 == 9'd0));
    assign prod7   = 32'(r_wsum) * 32'(DIV7_MUL);

    always_comb begin
        n_year   = r_year;
        n_month  = r_month;
        n_day    = r_day;
        n_hour   = r_hour;
        n_min    = r_min;
        n_wday   = r_wday;
        n_ym4    = r_ym4;
        n_ym100  = r_ym100;
        n_ym400  = r_ym400;
        n_q100   = r_q100;
        n_q400   = r_q400;
        n_wsum   = r_wsum;
        n_wq     = r_wq;
        n_cnt    = r_cnt;
        n_found  = r_found;
        n_ny     = r_ny;
        n_nm     = r_nm;
        n_nd     = r_nd;
        n_nh     = r_nh;
        n_nmin   = r_nmin;
        n_nwd    = r_nwd;
        go_day   = 1'b0;
        go_month = 1'b0;
        case (i_cmd)
            CMD_LOAD: begin
                n_year = {1'b0, i_start_year};
                if (i_start_month == 4'd0) begin
                    n_month = 4'd1;
                end else if (i_start_month > 4'(MON_LAST)) begin
                    n_month = 4'(MON_LAST);
                end else begin
                    n_month = i_start_month;
                end
                n_day  = i_start_day;
                n_hour = (i_start_hour > 5'(HOUR_LAST)) ? 5'(HOUR_LAST) : i_start_hour;
                n_min  = (i_start_minute > 6'(MIN_LAST)) ? 6'(MIN_LAST) : i_start_minute;
            end
            CMD_QUOT: begin
                n_q100 = prod100[DIV25_SHIFT+7:DIV25_SHIFT];
                n_q400 = prod400[DIV25_SHIFT+5:DIV25_SHIFT];
            end
            CMD_REM: begin
                n_ym4   = r_year[1:0];
                n_ym100 = 7'(r_year - 15'(r_q100) * 15'(CENTURY));
                n_ym400 = 9'(r_year - 15'(r_q400) * 15'(QUAD_CENTURY));
            end
            CMD_CLAMP: begin
                if (r_day == 5'd0) begin
                    n_day = 5'd1;
                end else if (r_day > mlen) begin
                    n_day = mlen;
                end
            end
            CMD_WSUM: begin
                n_wsum = ya + fa4 - fa100 + fa400 + 16'(month_offset(r_month))
                       + 16'(r_day);
            end
            CMD_WDIV: begin
                n_wq = prod7[DIV7_SHIFT+11:DIV7_SHIFT];
            end
            CMD_WREM: begin
                n_wday = 3'(r_wsum - 16'(r_wq) * 16'(WEEK_DAYS));
                n_cnt  = '0;
            end
            CMD_ADV_MIN: begin
                n_min  = am_min;
                n_hour = am_hour;
                go_day = am_roll;
            end
            CMD_STEP: begin
                if (miss) begin
                    n_found = 1'b0;
                    n_ny    = '0;
                    n_nm    = '0;
                    n_nd    = '0;
                    n_nh    = '0;
                    n_nmin  = '0;
                    n_nwd   = '0;
                end else if (!month_ok) begin
                    go_month = 1'b1;
                    n_hour   = 5'd0;
                    n_min    = 6'd0;
                end else if (!day_ok) begin
                    go_day = 1'b1;
                    n_hour = 5'd0;
                    n_min  = 6'd0;
                end else if (!hour_ok) begin
                    n_min = 6'd0;
                    if (r_hour == 5'(HOUR_LAST)) begin
                        n_hour = 5'd0;
                        go_day = 1'b1;
                    end else begin
                        n_hour = r_hour + 5'd1;
                    end
                end else if (!min_ok) begin
                    n_min  = am_min;
                    n_hour = am_hour;
                    go_day = am_roll;
                end else begin
                    n_found = 1'b1;
                    n_ny    = r_year[13:0];
                    n_nm    = r_month;
                    n_nd    = r_day;
                    n_nh    = r_hour;
                    n_nmin  = r_min;
                    n_nwd   = r_wday;
                end
            end
            default: begin
            end
        endcase

        if (go_month || (go_day && nd_wrap)) begin
            n_day   = 5'd1;
            n_month = nm_month;
            n_year  = nm_year;
            n_ym4   = nm_ym4;
            n_ym100 = nm_ym100;
            n_ym400 = nm_ym400;
        end else if (go_day) begin
            n_day = nd_day;
        end

        if (go_month) begin
            n_wday = nm_wday;
            n_cnt  = r_cnt + CNT_W'(nm_delta);
        end else if (go_day) begin
            n_wday = nd_wday;
            n_cnt  = r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_year  <= n_year;
        r_month <= n_month;
        r_day   <= n_day;
        r_hour  <= n_hour;
        r_min   <= n_min;
        r_wday  <= n_wday;
        r_ym4   <= n_ym4;
        r_ym100 <= n_ym100;
        r_ym400 <= n_ym400;
        r_q100  <= n_q100;
        r_q400  <= n_q400;
        r_wsum  <= n_wsum;
        r_wq    <= n_wq;
        r_cnt   <= n_cnt;
        r_found <= n_found;
        r_ny    <= n_ny;
        r_nm    <= n_nm;
        r_nd    <= n_nd;
        r_nh    <= n_nh;
        r_nmin  <= n_nmin;
        r_nwd   <= n_nwd;
    end

    assign o_found        = r_found;
    assign o_next_year    = r_ny;
    assign o_next_month   = r_nm;
    assign o_next_day     = r_nd;
    assign o_next_hour    = r_nh;
    assign o_next_minute  = r_nmin;
    assign o_next_weekday = r_nwd;

endmodule
